/* design/vertex_translate_rotate_xyz_defines.svh */
// assertion macros shared by the vertex transform files
`ifndef VERTEX_TRANSLATE_ROTATE_XYZ_DEFINES_SVH
`define VERTEX_TRANSLATE_ROTATE_XYZ_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define VTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define VTR_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VTR_ASSERT(lbl, prop, msg)
`define VTR_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

/* design/vtr_pkg.sv */
`timescale 1ns / 1ps
package vtr_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int COORD_BITS = 44;
  localparam int OUT_BITS   = 48;
  localparam int TRIG_BITS  = 12;
  localparam int TRIG_W     = TRIG_BITS + 2;
  localparam int ANGLE_W    = 9;
  localparam int SHIFT_W    = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = OUT_BITS + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 3'd0,
    CFG_ROT_X   = 3'd1,
    CFG_ROT_Y   = 3'd2,
    CFG_ROT_Z   = 3'd3,
    CFG_SHIFT_X = 3'd4,
    CFG_SHIFT_Y = 3'd5,
    CFG_SHIFT_Z = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x_out;
    logic signed [OUT_BITS-1:0] y_out;
    logic signed [OUT_BITS-1:0] z_out;
  } out_word_t;

  // vertex in flight, en marks an item that gets the transform
  typedef struct packed {
    logic                       en;
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic                      en;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [SHIFT_W-1:0] shift_z;
    trig_t                     trig_x;
    trig_t                     trig_y;
    trig_t                     trig_z;
  } cfg_t;

  // round(sin(d) * 4096), d = 0..90
  localparam logic [TRIG_W-2:0] QSIN [0:90] = '{
    13'd0,    13'd71,   13'd143,  13'd214,  13'd286,  13'd357,  13'd428,  13'd499,
    13'd570,  13'd641,  13'd711,  13'd782,  13'd852,  13'd921,  13'd991,  13'd1060,
    13'd1129, 13'd1198, 13'd1266, 13'd1334, 13'd1401, 13'd1468, 13'd1534, 13'd1600,
    13'd1666, 13'd1731, 13'd1796, 13'd1860, 13'd1923, 13'd1986, 13'd2048, 13'd2110,
    13'd2171, 13'd2231, 13'd2290, 13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578,
    13'd2633, 13'd2687, 13'd2741, 13'd2793, 13'd2845, 13'd2896, 13'd2946, 13'd2996,
    13'd3044, 13'd3091, 13'd3138, 13'd3183, 13'd3228, 13'd3271, 13'd3314, 13'd3355,
    13'd3396, 13'd3435, 13'd3474, 13'd3511, 13'd3547, 13'd3582, 13'd3617, 13'd3650,
    13'd3681, 13'd3712, 13'd3742, 13'd3770, 13'd3798, 13'd3824, 13'd3849, 13'd3873,
    13'd3896, 13'd3917, 13'd3937, 13'd3956, 13'd3974, 13'd3991, 13'd4006, 13'd4021,
    13'd4034, 13'd4046, 13'd4056, 13'd4065, 13'd4074, 13'd4080, 13'd4086, 13'd4090,
    13'd4094, 13'd4095, 13'd4096
  };

  // signed angle folded into 0..359
  function automatic logic [ANGLE_W-1:0] norm_deg(input logic signed [ANGLE_W-1:0] a);
    logic [ANGLE_W:0] t;
    t = {a[ANGLE_W-1], a} + (ANGLE_W+1)'(360);
    if (a[ANGLE_W-1]) begin
      return t[ANGLE_W-1:0];
    end
    return a;
  endfunction

  // quarter turn ahead, for the cosine
  function automatic logic [ANGLE_W-1:0] plus_quarter(input logic [ANGLE_W-1:0] d);
    logic [ANGLE_W:0] t;
    t = {1'b0, d} + (ANGLE_W+1)'(90);
    if (t >= (ANGLE_W+1)'(360)) begin
      t = t - (ANGLE_W+1)'(360);
    end
    return t[ANGLE_W-1:0];
  endfunction

  // sine in 2.12 of a whole-degree angle in 0..359
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANGLE_W-1:0] d);
    logic [ANGLE_W-1:0] i;
    logic               neg;
    logic [TRIG_W-1:0]  mag;
    if (d <= ANGLE_W'(90)) begin
      i   = d;
      neg = 1'b0;
    end else if (d <= ANGLE_W'(180)) begin
      i   = ANGLE_W'(180) - d;
      neg = 1'b0;
    end else if (d <= ANGLE_W'(270)) begin
      i   = d - ANGLE_W'(180);
      neg = 1'b1;
    end else begin
      i   = ANGLE_W'(360) - d;
      neg = 1'b1;
    end
    mag = {1'b0, QSIN[i[6:0]]};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

/* design/vtr_cfg.sv */
`timescale 1ns / 1ps
`include "vertex_translate_rotate_xyz_defines.svh"
module vtr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vtr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [vtr_pkg::CFG_W-1:0]      cfg_wdata,
  output vtr_pkg::cfg_t                  cfg
);
  import vtr_pkg::*;

  logic                      en_r;
  logic signed [ANGLE_W-1:0] rot_x_r, rot_y_r, rot_z_r;
  logic signed [SHIFT_W-1:0] shift_x_r, shift_y_r, shift_z_r;
  trig_t                     trig_x_r, trig_y_r, trig_z_r;
  trig_t                     trig_x_nxt, trig_y_nxt, trig_z_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b1;
      rot_x_r   <= '0;
      rot_y_r   <= '0;
      rot_z_r   <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENABLE:  en_r      <= cfg_wdata[0];
        CFG_ROT_X:   rot_x_r   <= cfg_wdata[ANGLE_W-1:0];
        CFG_ROT_Y:   rot_y_r   <= cfg_wdata[ANGLE_W-1:0];
        CFG_ROT_Z:   rot_z_r   <= cfg_wdata[ANGLE_W-1:0];
        CFG_SHIFT_X: shift_x_r <= cfg_wdata[SHIFT_W-1:0];
        CFG_SHIFT_Y: shift_y_r <= cfg_wdata[SHIFT_W-1:0];
        CFG_SHIFT_Z: shift_z_r <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // table lookup from the angle registers
  always_comb begin
    trig_x_nxt.sin_v = sin_deg(norm_deg(rot_x_r));
    trig_x_nxt.cos_v = sin_deg(plus_quarter(norm_deg(rot_x_r)));
    trig_y_nxt.sin_v = sin_deg(norm_deg(rot_y_r));
    trig_y_nxt.cos_v = sin_deg(plus_quarter(norm_deg(rot_y_r)));
    trig_z_nxt.sin_v = sin_deg(norm_deg(rot_z_r));
    trig_z_nxt.cos_v = sin_deg(plus_quarter(norm_deg(rot_z_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_x_r <= '{sin_v: '0, cos_v: TRIG_ONE};
      trig_y_r <= '{sin_v: '0, cos_v: TRIG_ONE};
      trig_z_r <= '{sin_v: '0, cos_v: TRIG_ONE};
    end else begin
      trig_x_r <= trig_x_nxt;
      trig_y_r <= trig_y_nxt;
      trig_z_r <= trig_z_nxt;
    end
  end

  assign cfg.en      = en_r;
  assign cfg.shift_x = shift_x_r;
  assign cfg.shift_y = shift_y_r;
  assign cfg.shift_z = shift_z_r;
  assign cfg.trig_x  = trig_x_r;
  assign cfg.trig_y  = trig_y_r;
  assign cfg.trig_z  = trig_z_r;

  `VTR_ASSERT(a_cfg_en_wr, cfg_we && cfg_idx == CFG_ENABLE |=> en_r == $past(cfg_wdata[0]), "enable write lost")
  `VTR_ASSERT(a_cfg_hold, !cfg_we |=> $stable(shift_x_r) && $stable(rot_x_r) && $stable(en_r), "config changed without write")
  `VTR_ASSERT(a_cfg_trig_rng, trig_y_r.cos_v <= TRIG_ONE && trig_y_r.cos_v >= -TRIG_ONE && trig_y_r.sin_v <= TRIG_ONE && trig_y_r.sin_v >= -TRIG_ONE, "trig out of range")

endmodule

/* design/vtr_rot.sv */
`timescale 1ns / 1ps
`include "vertex_translate_rotate_xyz_defines.svh"
module vtr_rot (
  input  logic           clk,
  input  logic           rst_n,
  input  vtr_pkg::axis_t axis,
  input  vtr_pkg::trig_t trig,
  input  logic           in_valid,
  output logic           in_ready,
  input  vtr_pkg::vec_t  in_vec,
  output logic           out_valid,
  input  logic           out_ready,
  output vtr_pkg::vec_t  out_vec
);
  import vtr_pkg::*;

  logic                       v1_r, v2_r;
  logic                       rdy1, rdy2;
  logic signed [OUT_BITS-1:0] a, b, a_new, b_new;
  logic signed [TRIG_W-1:0]   c, s;
  logic signed [PROD_W-1:0]   ca_r, sb_r, cb_r, sa_r;
  logic signed [SUM_W-1:0]    sum_a, sum_b, shf_a, shf_b;
  vec_t                       s1_vec_r, s2_vec_r, s2_vec_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // plane select, identity trig for pass-through words
  always_comb begin
    unique case (axis)
      AXIS_X: begin a = in_vec.y; b = in_vec.z; end
      AXIS_Y: begin a = in_vec.x; b = in_vec.z; end
      AXIS_Z: begin a = in_vec.x; b = in_vec.y; end
      default: begin a = in_vec.x; b = in_vec.y; end
    endcase
    c = in_vec.en ? trig.cos_v : TRIG_ONE;
    s = in_vec.en ? trig.sin_v : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage 1: four products
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_vec_r <= in_vec;
      ca_r     <= PROD_W'(a) * PROD_W'(c);
      sb_r     <= PROD_W'(b) * PROD_W'(s);
      cb_r     <= PROD_W'(b) * PROD_W'(c);
      sa_r     <= PROD_W'(a) * PROD_W'(s);
    end
  end

  // stage 2: sum and floor shift
  always_comb begin
    sum_a = SUM_W'(ca_r) + SUM_W'(sb_r);
    sum_b = SUM_W'(cb_r) - SUM_W'(sa_r);
    shf_a = sum_a >>> TRIG_BITS;
    shf_b = sum_b >>> TRIG_BITS;
    a_new = shf_a[OUT_BITS-1:0];
    b_new = shf_b[OUT_BITS-1:0];
    s2_vec_nxt = s1_vec_r;
    unique case (axis)
      AXIS_X: begin s2_vec_nxt.y = a_new; s2_vec_nxt.z = b_new; end
      AXIS_Y: begin s2_vec_nxt.x = a_new; s2_vec_nxt.z = b_new; end
      AXIS_Z: begin s2_vec_nxt.x = a_new; s2_vec_nxt.y = b_new; end
      default: begin s2_vec_nxt.x = a_new; s2_vec_nxt.y = b_new; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      s2_vec_r <= s2_vec_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_vec   = s2_vec_r;

  `VTR_ASSERT(a_rot_fill, in_valid && in_ready |=> v1_r, "accepted word not in stage 1")
  `VTR_ASSERT(a_rot_hold1, v1_r && !rdy2 |=> v1_r, "stage 1 word dropped")
  `VTR_ASSERT(a_rot_hold2, v2_r && !out_ready |=> v2_r && $stable(s2_vec_r), "stalled word lost")
  `VTR_ASSERT(a_rot_ident, v1_r && !s1_vec_r.en |-> sb_r == '0 && sa_r == '0, "pass-through word rotated")

endmodule

/* design/vertex_translate_rotate_xyz.sv */
`timescale 1ns / 1ps
`include "vertex_translate_rotate_xyz_defines.svh"
// fixed-point vertex transform: each input word carries one vertex (x, y, z,
// 12 fractional bits) and gives one output word. with enable set, x gains
// shift_x, y and z lose shift_y and shift_z (whole units), then the vertex
// is rotated about x on (y,z), about y on (x,z) and about z on (x,y), each
// with 2.12 sine/cosine from a whole-degree table and a floor shift by 12;
// with enable clear the vertex passes through sign-extended to 48 bits.
// throughput is one word per clock while out_stall is low, with one translate
// stage and two stages (multiply, then add and shift) per rotation, the
// multipliers being 48x14 bits. valid travels with each stage and a stage
// moves up whenever the one after it is empty or moving, so bubbles close up
// and input is still taken while a finished word waits on out_stall, as long
// as any stage is empty. config writes take effect at once for the shifts and
// enable, and in the next cycle for the angles (table lookup is registered).
module vertex_translate_rotate_xyz (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vtr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vtr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vtr_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vtr_pkg::out_word_t            out_word
);
  import vtr_pkg::*;

  cfg_t cfg;

  // translate stage
  logic t_valid_r;
  logic t_rdy;
  vec_t t_vec_r, t_vec_nxt;

  // rotation chain handshakes
  logic rx_rdy, rx_valid, ry_rdy, ry_valid, rz_rdy, rz_valid;
  vec_t rx_vec, ry_vec, rz_vec;

  vtr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign t_rdy    = !t_valid_r || rx_rdy;
  assign in_stall = !t_rdy;

  // integer shift moved up to the fixed-point grid; zero when disabled
  always_comb begin
    t_vec_nxt.en = cfg.en;
    t_vec_nxt.x  = OUT_BITS'(in_word.x_in);
    t_vec_nxt.y  = OUT_BITS'(in_word.y_in);
    t_vec_nxt.z  = OUT_BITS'(in_word.z_in);
    if (cfg.en) begin
      t_vec_nxt.x = t_vec_nxt.x + {{(OUT_BITS-SHIFT_W-FRAC_BITS){cfg.shift_x[SHIFT_W-1]}},
                                   cfg.shift_x, {FRAC_BITS{1'b0}}};
      t_vec_nxt.y = t_vec_nxt.y - {{(OUT_BITS-SHIFT_W-FRAC_BITS){cfg.shift_y[SHIFT_W-1]}},
                                   cfg.shift_y, {FRAC_BITS{1'b0}}};
      t_vec_nxt.z = t_vec_nxt.z - {{(OUT_BITS-SHIFT_W-FRAC_BITS){cfg.shift_z[SHIFT_W-1]}},
                                   cfg.shift_z, {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else if (t_rdy) begin
      t_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && t_rdy) begin
      t_vec_r <= t_vec_nxt;
    end
  end

  // rotation about x: (y,z) plane
  vtr_rot u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (AXIS_X),
    .trig      (cfg.trig_x),
    .in_valid  (t_valid_r),
    .in_ready  (rx_rdy),
    .in_vec    (t_vec_r),
    .out_valid (rx_valid),
    .out_ready (ry_rdy),
    .out_vec   (rx_vec)
  );

  // rotation about y: (x,z) plane
  vtr_rot u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (AXIS_Y),
    .trig      (cfg.trig_y),
    .in_valid  (rx_valid),
    .in_ready  (ry_rdy),
    .in_vec    (rx_vec),
    .out_valid (ry_valid),
    .out_ready (rz_rdy),
    .out_vec   (ry_vec)
  );

  // rotation about z: (x,y) plane, its last stage is the output register
  vtr_rot u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (AXIS_Z),
    .trig      (cfg.trig_z),
    .in_valid  (ry_valid),
    .in_ready  (rz_rdy),
    .in_vec    (ry_vec),
    .out_valid (rz_valid),
    .out_ready (!out_stall),
    .out_vec   (rz_vec)
  );

  assign out_valid      = rz_valid;
  assign out_word.x_out = rz_vec.x;
  assign out_word.y_out = rz_vec.y;
  assign out_word.z_out = rz_vec.z;

  `VTR_ASSERT_NORST(a_top_rst, !rst_n |=> !out_valid && !t_valid_r, "valid after reset")
  `VTR_ASSERT(a_top_fill, in_valid && !in_stall |=> t_valid_r, "accepted word not in translate stage")
  `VTR_ASSERT(a_top_bypass, in_valid && !in_stall && !cfg.en |=> t_vec_r.x == OUT_BITS'($past(in_word.x_in)) && !t_vec_r.en, "pass-through word translated")

endmodule
